>>> rtl/core/lfk_pkg.sv
// package: types and fixed constants for the leg forward kinematics block
package lfk_pkg;

    // angle format of the joint inputs (fraction bits)
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

    // datapath widths
    localparam int ANG_W  = 36;
    localparam int XY_W   = 34;
    localparam int TRIG_W = 32;
    localparam int POS_W  = 20;
    localparam int VEL_W  = 32;
    localparam int LEN_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ATAN_LEN   = 24;

    // q30 constants
    localparam logic signed [ANG_W-1:0] Q30_PI       = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI  = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI   = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  CORDIC_START = 34'sd652032874;

    // truncated q30 arctangent table
    localparam logic [31:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_SIDE   = 3'd0,
        CFG_HIP_LENGTH   = 3'd1,
        CFG_THIGH_LENGTH = 3'd2,
        CFG_CALF_LENGTH  = 3'd3,
        CFG_FOOT_RADIUS  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] abduct_angle;
        logic signed [15:0] hip_angle;
        logic signed [15:0] knee_angle;
        logic signed [15:0] abduct_rate;
        logic signed [15:0] hip_rate;
        logic signed [15:0] knee_rate;
    } t_lfk_in;

    typedef struct packed {
        logic signed [POS_W-1:0] foot_pos_x;
        logic signed [POS_W-1:0] foot_pos_y;
        logic signed [POS_W-1:0] foot_pos_z;
        logic signed [VEL_W-1:0] foot_vel_x;
        logic signed [VEL_W-1:0] foot_vel_y;
        logic signed [VEL_W-1:0] foot_vel_z;
    } t_lfk_out;

    typedef struct packed {
        logic signed [15:0] abduct;
        logic signed [15:0] hip;
        logic signed [15:0] knee;
    } t_rates;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [21:0] v);
        logic signed [21:0] hi;
        logic signed [21:0] lo;
        hi = 22'sd524287;
        lo = -22'sd524288;
        if (v > hi) begin
            sat_pos = hi[POS_W-1:0];
        end else if (v < lo) begin
            sat_pos = lo[POS_W-1:0];
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi) begin
            sat_vel = hi[VEL_W-1:0];
        end else if (v < lo) begin
            sat_vel = lo[VEL_W-1:0];
        end else begin
            sat_vel = v[VEL_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/leg_forward_kinematics_top.sv
// top level: pipelined leg forward kinematics (foot position and velocity)
//
//  channel   dir  handshake                     beat
//  in        in   i_in_valid / o_in_stall       i_in_data  (angles q2.13, rates q5.10)
//  out       out  o_out_valid / i_out_stall     o_out_data (pos q3.16, vel q15.16)
//  cfg       in   i_cfg_wr_en                   i_cfg_index, i_cfg_data
//
//  one beat per cycle sustained while the output is not stalled; the stages are
//  input, wrap, fold, one cordic stage per iteration, trig, then six product/sum stages
//  the cordic chain sets the depth: three angles run side by side, one iteration per stage
//  synchronous active-low reset clears only the stage valid bits and the config registers
//  each stage holds its beat while the next is full; bubbles close up, so input is
//  taken while a finished beat waits at the output
module leg_forward_kinematics_top #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lfk_pkg::t_lfk_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lfk_pkg::t_lfk_out         o_out_data,
    input  logic                      i_cfg_wr_en,
    input  logic [lfk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfk_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lfk_pkg::*;

    // stage map
    localparam int ST_IN    = 0;
    localparam int ST_WRAP  = 1;
    localparam int ST_FOLD  = 2;
    localparam int ST_CORD0 = 3;
    localparam int ST_TRIG  = ST_CORD0 + TRIG_ITERATIONS;
    localparam int ST_M1    = ST_TRIG + 1;
    localparam int ST_SUM1  = ST_TRIG + 2;
    localparam int ST_M2    = ST_TRIG + 3;
    localparam int ST_SUM2  = ST_TRIG + 4;
    localparam int ST_M3    = ST_TRIG + 5;
    localparam int ST_OUT   = ST_TRIG + 6;
    localparam int NS       = ST_OUT + 1;

    // configuration registers
    logic             r_right_side;
    logic [LEN_W-1:0] r_hip_len;
    logic [LEN_W-1:0] r_thigh_len;
    logic [LEN_W-1:0] r_calf_len;
    logic [LEN_W-1:0] r_foot_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_side <= 1'b0;
            r_hip_len    <= '0;
            r_thigh_len  <= '0;
            r_calf_len   <= '0;
            r_foot_rad   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RIGHT_SIDE:   r_right_side <= i_cfg_data[0];
                CFG_HIP_LENGTH:   r_hip_len    <= i_cfg_data;
                CFG_THIGH_LENGTH: r_thigh_len  <= i_cfg_data;
                CFG_CALF_LENGTH:  r_calf_len   <= i_cfg_data;
                CFG_FOOT_RADIUS:  r_foot_rad   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // calf plus foot sphere, 17 bits unsigned
    logic [LEN_W:0] w_lc;
    assign w_lc = {1'b0, r_calf_len} + {1'b0, r_foot_rad};

    // valid bits and per-stage load enables (a stage loads when empty or when
    // the stage after it moves)
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_stall  = !w_en[ST_IN];
    assign o_out_valid = r_v[ST_OUT];

    // rates ride along until the velocity stages
    t_rates r_rates [0:ST_SUM2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_rates[ST_IN] <= '{abduct: i_in_data.abduct_rate, hip: i_in_data.hip_rate,
                                knee: i_in_data.knee_rate};
        end
        for (int k = 1; k <= ST_SUM2; k++) begin
            if (w_en[k]) begin
                r_rates[k] <= r_rates[k-1];
            end
        end
    end

    // input stage: angles to q30, channel 0 abduction, 1 hip, 2 hip+knee
    logic signed [ANG_W-1:0] r_ang [0:2];
    logic signed [16:0]      w_hk_sum;

    assign w_hk_sum = 17'(i_in_data.hip_angle) + 17'(i_in_data.knee_angle);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_ang[0] <= ANG_W'(i_in_data.abduct_angle) <<< ANG_SHIFT;
            r_ang[1] <= ANG_W'(i_in_data.hip_angle) <<< ANG_SHIFT;
            r_ang[2] <= ANG_W'(w_hk_sum) <<< ANG_SHIFT;
        end
    end

    // wrap into [-pi, pi]; inputs stay below three pi in magnitude
    logic signed [ANG_W-1:0] r_wrap [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_WRAP]) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_ang[ch] > Q30_PI) begin
                    r_wrap[ch] <= r_ang[ch] - Q30_TWO_PI;
                end else if (r_ang[ch] < -Q30_PI) begin
                    r_wrap[ch] <= r_ang[ch] + Q30_TWO_PI;
                end else begin
                    r_wrap[ch] <= r_ang[ch];
                end
            end
        end
    end

    // fold into [-pi/2, pi/2], remember the sign flip
    logic signed [XY_W-1:0] r_fold_z [0:2];
    logic                   r_fold_f [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_FOLD]) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_wrap[ch] > Q30_HALF_PI) begin
                    r_fold_z[ch] <= XY_W'(r_wrap[ch] - Q30_PI);
                    r_fold_f[ch] <= 1'b1;
                end else if (r_wrap[ch] < -Q30_HALF_PI) begin
                    r_fold_z[ch] <= XY_W'(r_wrap[ch] + Q30_PI);
                    r_fold_f[ch] <= 1'b1;
                end else begin
                    r_fold_z[ch] <= XY_W'(r_wrap[ch]);
                    r_fold_f[ch] <= 1'b0;
                end
            end
        end
    end

    // cordic rotation, one iteration per stage
    logic signed [XY_W-1:0] r_cx [0:TRIG_ITERATIONS-1][0:2];
    logic signed [XY_W-1:0] r_cy [0:TRIG_ITERATIONS-1][0:2];
    logic signed [XY_W-1:0] r_cz [0:TRIG_ITERATIONS-1][0:2];
    logic                   r_cf [0:TRIG_ITERATIONS-1][0:2];

    for (genvar gi = 0; gi < TRIG_ITERATIONS; gi++) begin : g_cord
        logic signed [XY_W-1:0] w_px [0:2];
        logic signed [XY_W-1:0] w_py [0:2];
        logic signed [XY_W-1:0] w_pz [0:2];
        logic                   w_pf [0:2];
        logic signed [XY_W-1:0] w_atan;

        assign w_atan = signed'({2'b00, ATAN_Q30[gi]});

        always_comb begin
            for (int ch = 0; ch < 3; ch++) begin
                if (gi == 0) begin
                    w_px[ch] = CORDIC_START;
                    w_py[ch] = '0;
                    w_pz[ch] = r_fold_z[ch];
                    w_pf[ch] = r_fold_f[ch];
                end else begin
                    w_px[ch] = r_cx[(gi == 0) ? 0 : gi - 1][ch];
                    w_py[ch] = r_cy[(gi == 0) ? 0 : gi - 1][ch];
                    w_pz[ch] = r_cz[(gi == 0) ? 0 : gi - 1][ch];
                    w_pf[ch] = r_cf[(gi == 0) ? 0 : gi - 1][ch];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_CORD0+gi]) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_cf[gi][ch] <= w_pf[ch];
                    if (!w_pz[ch][XY_W-1]) begin
                        r_cx[gi][ch] <= w_px[ch] - (w_py[ch] >>> gi);
                        r_cy[gi][ch] <= w_py[ch] + (w_px[ch] >>> gi);
                        r_cz[gi][ch] <= w_pz[ch] - w_atan;
                    end else begin
                        r_cx[gi][ch] <= w_px[ch] + (w_py[ch] >>> gi);
                        r_cy[gi][ch] <= w_py[ch] - (w_px[ch] >>> gi);
                        r_cz[gi][ch] <= w_pz[ch] + w_atan;
                    end
                end
            end
        end
    end

    // q30 cosine and sine, fold flip undone
    logic signed [TRIG_W-1:0] r_tc [0:2];
    logic signed [TRIG_W-1:0] r_ts [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TRIG]) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_cf[TRIG_ITERATIONS-1][ch]) begin
                    r_tc[ch] <= TRIG_W'(-r_cx[TRIG_ITERATIONS-1][ch]);
                    r_ts[ch] <= TRIG_W'(-r_cy[TRIG_ITERATIONS-1][ch]);
                end else begin
                    r_tc[ch] <= TRIG_W'(r_cx[TRIG_ITERATIONS-1][ch]);
                    r_ts[ch] <= TRIG_W'(r_cy[TRIG_ITERATIONS-1][ch]);
                end
            end
        end
    end

    // link products, q46
    logic signed [49:0]       r_lc_chk, r_lt_chp, r_lc_shk, r_lt_shp;
    logic signed [48:0]       r_hc_p, r_hs_p;
    logic signed [TRIG_W-1:0] r_m1_cab, r_m1_sab;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_M1]) begin
            r_lc_chk <= signed'({1'b0, w_lc}) * r_tc[2];
            r_lc_shk <= signed'({1'b0, w_lc}) * r_ts[2];
            r_lt_chp <= signed'({2'b00, r_thigh_len}) * r_tc[1];
            r_lt_shp <= signed'({2'b00, r_thigh_len}) * r_ts[1];
            r_hc_p   <= signed'({1'b0, r_hip_len}) * r_tc[0];
            r_hs_p   <= signed'({1'b0, r_hip_len}) * r_ts[0];
            r_m1_cab <= r_tc[0];
            r_m1_sab <= r_ts[0];
        end
    end

    // planar terms a, b, e, f rounded to q16; side sign on the hip offset
    logic signed [19:0]       r_a, r_b, r_e, r_f;
    logic signed [49:0]       r_hc, r_hs;
    logic signed [TRIG_W-1:0] r_s1_cab, r_s1_sab;
    logic signed [50:0]       w_sa, w_sb, w_se, w_sf;
    logic signed [50:0]       w_half30;

    assign w_half30 = 51'sd536870912;
    assign w_sa = 51'(r_lc_chk) + 51'(r_lt_chp) + w_half30;
    assign w_sb = 51'(r_lc_shk) + 51'(r_lt_shp) + w_half30;
    assign w_se = 51'(r_lc_chk) + w_half30;
    assign w_sf = 51'(r_lc_shk) + w_half30;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM1]) begin
            r_a <= 20'(w_sa >>> 30);
            r_b <= 20'(w_sb >>> 30);
            r_e <= 20'(w_se >>> 30);
            r_f <= 20'(w_sf >>> 30);
            r_hc <= r_right_side ? -50'(r_hc_p) : 50'(r_hc_p);
            r_hs <= r_right_side ? -50'(r_hs_p) : 50'(r_hs_p);
            r_s1_cab <= r_m1_cab;
            r_s1_sab <= r_m1_sab;
        end
    end

    // second products
    logic signed [51:0]       r_sab_a, r_cab_a;
    logic signed [35:0]       r_a_rh, r_e_rk, r_b_rh, r_f_rk;
    logic signed [49:0]       r_m2_hc, r_m2_hs;
    logic signed [19:0]       r_m2_b;
    logic signed [TRIG_W-1:0] r_m2_cab, r_m2_sab;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_M2]) begin
            r_sab_a  <= r_s1_sab * r_a;
            r_cab_a  <= r_s1_cab * r_a;
            r_a_rh   <= r_a * r_rates[ST_SUM1].hip;
            r_e_rk   <= r_e * r_rates[ST_SUM1].knee;
            r_b_rh   <= r_b * r_rates[ST_SUM1].hip;
            r_f_rk   <= r_f * r_rates[ST_SUM1].knee;
            r_m2_hc  <= r_hc;
            r_m2_hs  <= r_hs;
            r_m2_b   <= r_b;
            r_m2_cab <= r_s1_cab;
            r_m2_sab <= r_s1_sab;
        end
    end

    // position y, z and the hip-plane velocity terms
    logic signed [21:0]       r_py, r_pz;
    logic signed [27:0]       r_vx, r_g;
    logic signed [19:0]       r_s2_px;
    logic signed [TRIG_W-1:0] r_s2_cab, r_s2_sab;
    logic signed [53:0]       w_spy, w_spz;
    logic signed [37:0]       w_svx, w_sg;

    assign w_spy = 54'(r_m2_hc) + 54'(r_sab_a) + 54'sd536870912;
    assign w_spz = 54'(r_m2_hs) - 54'(r_cab_a) + 54'sd536870912;
    assign w_svx = 38'(r_a_rh) + 38'(r_e_rk) + 38'sd512;
    assign w_sg  = 38'(r_b_rh) + 38'(r_f_rk) + 38'sd512;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM2]) begin
            r_py     <= 22'(w_spy >>> 30);
            r_pz     <= 22'(w_spz >>> 30);
            r_vx     <= 28'(w_svx >>> 10);
            r_g      <= 28'(w_sg >>> 10);
            r_s2_px  <= r_m2_b;
            r_s2_cab <= r_m2_cab;
            r_s2_sab <= r_m2_sab;
        end
    end

    // abduction products
    logic signed [37:0] r_pz_ra, r_py_ra;
    logic signed [59:0] r_sab_g, r_cab_g;
    logic signed [19:0] r_m3_px;
    logic signed [21:0] r_m3_py, r_m3_pz;
    logic signed [27:0] r_m3_vx;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_M3]) begin
            r_pz_ra <= r_pz * r_rates[ST_SUM2].abduct;
            r_py_ra <= r_py * r_rates[ST_SUM2].abduct;
            r_sab_g <= r_s2_sab * r_g;
            r_cab_g <= r_s2_cab * r_g;
            r_m3_px <= r_s2_px;
            r_m3_py <= r_py;
            r_m3_pz <= r_pz;
            r_m3_vx <= r_vx;
        end
    end

    // final rounding and saturation into the output register
    logic signed [63:0] w_svy, w_svz;

    assign w_svy = -(64'(r_pz_ra) <<< 20) - 64'(r_sab_g) + 64'sd536870912;
    assign w_svz = (64'(r_py_ra) <<< 20) + 64'(r_cab_g) + 64'sd536870912;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            o_out_data.foot_pos_x <= sat_pos(22'(r_m3_px));
            o_out_data.foot_pos_y <= sat_pos(r_m3_py);
            o_out_data.foot_pos_z <= sat_pos(r_m3_pz);
            o_out_data.foot_vel_x <= sat_vel(36'(r_m3_vx));
            o_out_data.foot_vel_y <= sat_vel(36'(w_svy >>> 30));
            o_out_data.foot_vel_z <= sat_vel(36'(w_svz >>> 30));
        end
    end

    // checks
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> r_v == '0)
        else $error("pipeline not empty after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v))
        else $error("input stalled with a free stage");

    a_beat_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !(o_out_valid && !i_out_stall))
        |=> $countones(r_v) == $past($countones(r_v)) + 1)
        else $error("accepted beat lost in pipeline");

    a_beat_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && !o_in_stall) && o_out_valid && !i_out_stall)
        |=> $countones(r_v) + 1 == $past($countones(r_v)))
        else $error("beat count wrong after delivery");

endmodule

>>> dv/tb_top.sv
// testbench for the leg forward kinematics block: scoreboard, stimulus and checks
`timescale 1ns / 100ps

module tb_top;
    import lfk_pkg::*;

    localparam int TRIG_ITERATIONS = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int LATENCY_WAIT = 40;      // pipeline depth is 26, plus margin
    localparam int WATCHDOG_LIMIT = 20000; // cycles with no beat moving on either side
    localparam int PRESSURE_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 155;

    // scoreboard: predicts foot position/velocity and checks delivered beats in order
    class kin_scoreboard;
        bit          right_leg;
        longint      hip_len, thigh_len, calf_len, foot_rad;
        t_lfk_out    expected_q[$];
        int          errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_RIGHT_SIDE:   right_leg = d[0];
                CFG_HIP_LENGTH:   hip_len   = longint'(d);
                CFG_THIGH_LENGTH: thigh_len = longint'(d);
                CFG_CALF_LENGTH:  calf_len  = longint'(d);
                CFG_FOOT_RADIUS:  foot_rad  = longint'(d);
                default: ;
            endcase
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        // rotation-mode cordic on a q30 angle, result q30
        function void sin_cos(longint ang, output longint c, output longint s);
            longint r, x, y, nx;
            bit     flip;
            r = ang % longint'(Q30_TWO_PI);
            x = longint'(CORDIC_START);
            y = 0;
            flip = 0;
            if (r > longint'(Q30_PI)) r -= longint'(Q30_TWO_PI);
            else if (r < -longint'(Q30_PI)) r += longint'(Q30_TWO_PI);
            if (r > longint'(Q30_HALF_PI)) begin
                r -= longint'(Q30_PI);
                flip = 1;
            end else if (r < -longint'(Q30_HALF_PI)) begin
                r += longint'(Q30_PI);
                flip = 1;
            end
            for (int i = 0; i < TRIG_ITERATIONS; i++) begin
                if (r >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    r -= longint'(ATAN_Q30[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    r += longint'(ATAN_Q30[i]);
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_input(t_lfk_in it);
            longint ab, hp, kn, rab, rhp, rkn;
            longint cab, sab, chp, shp, chk, shk, lc;
            longint a, b, e, f, hc, hs, py, pz, vx, vy, vz, g;
            t_lfk_out o;
            ab = longint'(it.abduct_angle) * (longint'(1) <<< ANG_SHIFT);
            hp = longint'(it.hip_angle) * (longint'(1) <<< ANG_SHIFT);
            kn = longint'(it.knee_angle) * (longint'(1) <<< ANG_SHIFT);
            rab = longint'(it.abduct_rate);
            rhp = longint'(it.hip_rate);
            rkn = longint'(it.knee_rate);
            sin_cos(ab, cab, sab);
            sin_cos(hp, chp, shp);
            sin_cos(hp + kn, chk, shk);
            lc = calf_len + foot_rad;
            a = rnd(lc * chk + thigh_len * chp, 30);
            b = rnd(lc * shk + thigh_len * shp, 30);
            e = rnd(lc * chk, 30);
            f = rnd(lc * shk, 30);
            hc = right_leg ? -(hip_len * cab) : hip_len * cab;
            hs = right_leg ? -(hip_len * sab) : hip_len * sab;
            py = rnd(hc + sab * a, 30);
            pz = rnd(hs - cab * a, 30);
            vx = rnd(a * rhp + e * rkn, 10);
            g  = rnd(b * rhp + f * rkn, 10);
            vy = rnd(-(pz * rab) * (longint'(1) <<< 20) - sab * g, 30);
            vz = rnd(py * rab * (longint'(1) <<< 20) + cab * g, 30);
            o.foot_pos_x = POS_W'(clamp(b, POS_W));
            o.foot_pos_y = POS_W'(clamp(py, POS_W));
            o.foot_pos_z = POS_W'(clamp(pz, POS_W));
            o.foot_vel_x = VEL_W'(clamp(vx, VEL_W));
            o.foot_vel_y = VEL_W'(clamp(vy, VEL_W));
            o.foot_vel_z = VEL_W'(clamp(vz, VEL_W));
            expected_q.push_back(o);
        endfunction

        function void check(t_lfk_out got);
            t_lfk_out w;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (got.foot_pos_x !== w.foot_pos_x) begin
                $display("%0t: pos_x exp %0d got %0d", $time, w.foot_pos_x, got.foot_pos_x);
                errors++;
            end
            if (got.foot_pos_y !== w.foot_pos_y) begin
                $display("%0t: pos_y exp %0d got %0d", $time, w.foot_pos_y, got.foot_pos_y);
                errors++;
            end
            if (got.foot_pos_z !== w.foot_pos_z) begin
                $display("%0t: pos_z exp %0d got %0d", $time, w.foot_pos_z, got.foot_pos_z);
                errors++;
            end
            if (got.foot_vel_x !== w.foot_vel_x) begin
                $display("%0t: vel_x exp %0d got %0d", $time, w.foot_vel_x, got.foot_vel_x);
                errors++;
            end
            if (got.foot_vel_y !== w.foot_vel_y) begin
                $display("%0t: vel_y exp %0d got %0d", $time, w.foot_vel_y, got.foot_vel_y);
                errors++;
            end
            if (got.foot_vel_z !== w.foot_vel_z) begin
                $display("%0t: vel_z exp %0d got %0d", $time, w.foot_vel_z, got.foot_vel_z);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_in_valid = 0;
    logic                   o_in_stall;
    t_lfk_in                i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 0;
    t_lfk_out               o_out_data;
    logic                   i_cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    kin_scoreboard kin_sb = new();

    int  send_idle_pct = 0;   // chance per beat of sender gaps
    int  stall_pct = 0;       // chance per cycle of receiver stall
    bit  hold_off_req = 0;    // asks the receiver process for one long stall
    bit  in_fire_s, out_fire_s;
    t_lfk_out out_beat_s;
    int  quiet_cycles = 0;

    leg_forward_kinematics_top #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_top (.*);

    always #1 i_clk = ~i_clk;

    // sample handshakes mid-cycle; the values hold until the next rising edge
    always @(negedge i_clk) begin
        in_fire_s  = i_in_valid && !o_in_stall;
        out_fire_s = o_out_valid && !i_out_stall;
        out_beat_s = o_out_data;
    end

    // output monitor: every accepted beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire_s) begin
            kin_sb.check(out_beat_s);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        int hold_cnt;
        bit hold_used;
        if (hold_off_req && !hold_used) begin
            hold_cnt = PRESSURE_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: no beat moving for too long ends the run
    always @(posedge i_clk) begin
        if (in_fire_s || out_fire_s || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one beat; returns right after the edge that accepted it
    task automatic send_beat(t_lfk_in it);
        bit taken;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        kin_sb.note_input(it);
    endtask

    task automatic send_angles(int ab, int hp, int kn, int rab, int rhp, int rkn);
        t_lfk_in it;
        it.abduct_angle = 16'(ab);
        it.hip_angle    = 16'(hp);
        it.knee_angle   = 16'(kn);
        it.abduct_rate  = 16'(rab);
        it.hip_rate     = 16'(rhp);
        it.knee_rate    = 16'(rkn);
        send_beat(it);
    endtask

    // drain the pipe, then write all five registers plus an unused index
    task automatic load_config(bit rs, logic [15:0] hip, logic [15:0] thigh,
                               logic [15:0] calf, logic [15:0] foot);
        logic [CFG_DATA_W-1:0] vals [5];
        i_in_valid <= 1'b0;
        while (kin_sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        // upper data bits on the side register must be dropped
        vals = '{{15'h7FFF, rs}, hip, thigh, calf, foot};
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= i[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[i];
            kin_sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_UNUSED_IDX;
        i_cfg_data  <= 16'hFFFF;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // random joint sets: mostly realistic angles, some full-range words
    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                send_angles($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_angles($urandom_range(0, 25736) - 12868, $urandom_range(0, 25736) - 12868,
                            $urandom_range(0, 25736) - 12868, $urandom_range(0, 20480) - 10240,
                            $urandom_range(0, 20480) - 10240, $urandom_range(0, 20480) - 10240);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero lengths after reset: everything must come out zero
        send_angles(0, 0, 0, 0, 0, 0);
        send_angles(-32768, 32767, -32768, 32767, -32768, 32767);
        send_angles(12868, -12868, 25736, 1024, -1024, 2048);

        // typical left leg
        load_config(1'b0, 16'h1400, 16'h3800, 16'h3800, 16'h0500);
        send_angles(0, 0, 0, 0, 0, 0);
        send_angles(12868, 12868, -12868, 1024, 1024, 1024);     // quarter turns
        send_angles(25736, -25736, 25736, -1024, 0, 1024);       // near pi, fold path
        send_angles(32767, 32767, 32767, 32767, 32767, 32767);   // large angles wrap
        send_angles(-32768, -32768, -32768, -32768, -32768, -32768);
        send_angles(6434, 19302, 19302, 5000, -7000, 9000);      // hip+knee at 3*pi/2, past pi
        send_angles(-19302, 0, -25736, 0, 32767, -32768);
        send_angles(1, -1, 1, 1, -1, 1);

        // longest links on a right leg: largest outputs, still short of saturation
        load_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(0, 0, 0, 32767, 32767, 32767);
        send_angles(12868, -12868, 0, -32768, -32768, -32768);
        send_angles(-12868, 6434, 6434, 32767, -32768, 32767);
        send_angles(32767, -32768, 32767, -32768, 32767, -32768);
        send_angles(0, 25736, 0, 0, 0, 0);

        // random phases with mixed configs and idling patterns
        load_config(1'b0, 16'h1400, 16'h3800, 16'h3800, 16'h0500);
        random_phase(ITEMS_PER_PHASE);

        load_config(1'b1, 16'h1800, 16'h4000, 16'h3C00, 16'h0400);
        send_idle_pct = 68;
        stall_pct = 0;
        random_phase(ITEMS_PER_PHASE);

        load_config(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_idle_pct = 0;
        stall_pct = 68;
        random_phase(ITEMS_PER_PHASE);

        // long receiver hold-off while the sender keeps pushing: pipe fills, input stalls
        load_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_req = 1;
        random_phase(ITEMS_PER_PHASE);

        load_config(1'b0, 16'h0000, 16'h8000, 16'h0000, 16'h8000);
        send_idle_pct = 22;
        stall_pct = 22;
        random_phase(ITEMS_PER_PHASE);

        load_config(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        random_phase(ITEMS_PER_PHASE);

        i_in_valid <= 1'b0;
        while (kin_sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (kin_sb.errors == 0 && kin_sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
